@@ design/abaps_pkg.sv @@
// Shared types and constants for the ADC block average and peak smoother.
// Depends on nothing; the front, back and top modules import it.
package abaps_pkg;

	localparam int SMP_W          = 12;
	localparam int SLOW_SUM_W     = 20;
	localparam int SUPPLY_SUM_W   = 18;
	localparam int SLOW_CNT_W     = 8;
	localparam int FAST_CNT_W     = 6;
	localparam int SLOW_WINDOW_DEF = 250;
	localparam int FAST_WINDOW_DEF = 40;
	localparam int JOB_DEPTH      = 2;
	localparam int RES_DEPTH      = 2;

	// old + 9*peak fits in 16 bits; /10 as multiply by ceil(2^20/10), exact below 2^16
	localparam int BLEND_W     = 16;
	localparam int BLEND_SHIFT = 20;
	localparam int BLEND_RCP_W = 17;
	localparam logic [BLEND_RCP_W-1:0] BLEND_RECIP = 17'd104858;

	typedef struct packed {
		logic             slow_valid;
		logic [SMP_W-1:0] switch_a_sample;
		logic [SMP_W-1:0] switch_b_sample;
		logic             fast_valid;
		logic [SMP_W-1:0] reverse_sample;
		logic [SMP_W-1:0] forward_sample;
		logic [SMP_W-1:0] supply_sample;
		logic             transmitting;
	} conv_t;

	typedef struct packed {
		logic [SMP_W-1:0] switch_a_mean;
		logic [SMP_W-1:0] switch_b_mean;
		logic [SMP_W-1:0] supply_mean;
		logic [SMP_W-1:0] reverse_level;
		logic [SMP_W-1:0] forward_level;
		logic             slow_done;
		logic             fast_done;
	} result_t;

	// work handed from the front to the back for one item
	typedef struct packed {
		logic                    slow_done;
		logic                    fast_done;
		logic                    blend_en;
		logic [SLOW_SUM_W-1:0]   switch_a_sum;
		logic [SLOW_SUM_W-1:0]   switch_b_sum;
		logic [SUPPLY_SUM_W-1:0] supply_sum;
		logic [SMP_W-1:0]        reverse_peak;
		logic [SMP_W-1:0]        forward_peak;
	} job_t;

endpackage

@@ design/abaps_fifo.sv @@
// Small register FIFO used for the job queue and the result queue.
// Depends on nothing; item type and depth (a power of two) come in as parameters.
module abaps_fifo #(
	parameter type item_t = logic,
	parameter int  DEPTH  = 2
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t wdata,
	output logic  full,
	input  logic  pop,
	output item_t rdata,
	output logic  empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	item_t         mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

@@ design/abaps_front.sv @@
// Front end: window accumulators, counters and transmit peaks; emits one job per item.
// Depends on abaps_pkg.
module abaps_front #(
	parameter int SLOW_WINDOW = abaps_pkg::SLOW_WINDOW_DEF,
	parameter int FAST_WINDOW = abaps_pkg::FAST_WINDOW_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  abaps_pkg::conv_t   conv,
	output abaps_pkg::job_t    job
);
	import abaps_pkg::*;

	logic [SLOW_SUM_W-1:0]   a_sum_q, b_sum_q;
	logic [SUPPLY_SUM_W-1:0] sup_sum_q;
	logic [SLOW_CNT_W-1:0]   slow_cnt_q;
	logic [FAST_CNT_W-1:0]   fast_cnt_q;
	logic [SMP_W-1:0]        rev_peak_q, fwd_peak_q;

	logic [SLOW_SUM_W-1:0]   a_sum_d, b_sum_d;
	logic [SUPPLY_SUM_W-1:0] sup_sum_d;
	logic [SLOW_CNT_W-1:0]   slow_cnt_d;
	logic [FAST_CNT_W-1:0]   fast_cnt_d;
	logic [SMP_W-1:0]        rev_peak_d, fwd_peak_d;
	logic                    slow_end, fast_end;
	logic                    peak_en;

	always_comb begin
		slow_cnt_d = slow_cnt_q + 1'b1;
		a_sum_d    = a_sum_q + SLOW_SUM_W'(conv.switch_a_sample);
		b_sum_d    = b_sum_q + SLOW_SUM_W'(conv.switch_b_sample);
		slow_end   = conv.slow_valid && (slow_cnt_d >= SLOW_CNT_W'(SLOW_WINDOW));

		fast_cnt_d = fast_cnt_q + 1'b1;
		sup_sum_d  = sup_sum_q + SUPPLY_SUM_W'(conv.supply_sample);
		fast_end   = conv.fast_valid && (fast_cnt_d >= FAST_CNT_W'(FAST_WINDOW));

		peak_en    = conv.fast_valid && conv.transmitting;
		rev_peak_d = (peak_en && conv.reverse_sample > rev_peak_q) ? conv.reverse_sample
		                                                            : rev_peak_q;
		fwd_peak_d = (peak_en && conv.forward_sample > fwd_peak_q) ? conv.forward_sample
		                                                            : fwd_peak_q;
	end

	always_comb begin
		job.slow_done    = slow_end;
		job.fast_done    = fast_end;
		job.blend_en     = fast_end && conv.transmitting;
		job.switch_a_sum = a_sum_d;
		job.switch_b_sum = b_sum_d;
		job.supply_sum   = sup_sum_d;
		job.reverse_peak = rev_peak_d;
		job.forward_peak = fwd_peak_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_sum_q    <= '0;
			b_sum_q    <= '0;
			slow_cnt_q <= '0;
			sup_sum_q  <= '0;
			fast_cnt_q <= '0;
			rev_peak_q <= '0;
			fwd_peak_q <= '0;
		end else if (accept) begin
			if (conv.slow_valid) begin
				a_sum_q    <= slow_end ? '0 : a_sum_d;
				b_sum_q    <= slow_end ? '0 : b_sum_d;
				slow_cnt_q <= slow_end ? '0 : slow_cnt_d;
			end
			if (conv.fast_valid) begin
				sup_sum_q  <= fast_end ? '0 : sup_sum_d;
				fast_cnt_q <= fast_end ? '0 : fast_cnt_d;
				rev_peak_q <= fast_end ? '0 : rev_peak_d;
				fwd_peak_q <= fast_end ? '0 : fwd_peak_d;
			end
		end
	end

endmodule

@@ design/abaps_back.sv @@
// Back end: block means by reciprocal multiply, peak blend, held outputs.
// Depends on abaps_pkg; takes jobs from the job queue, feeds the result queue.
module abaps_back #(
	parameter int SLOW_WINDOW = abaps_pkg::SLOW_WINDOW_DEF,
	parameter int FAST_WINDOW = abaps_pkg::FAST_WINDOW_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  abaps_pkg::job_t     job,
	input  logic                job_empty,
	output logic                job_pop,
	input  logic                res_full,
	output logic                res_push,
	output abaps_pkg::result_t  result
);
	import abaps_pkg::*;

	// q = (x * ceil(2^S/d)) >> S with S = width(x) + clog2(d) is exact for all x
	localparam int SLOW_SHIFT = SLOW_SUM_W + $clog2(SLOW_WINDOW);
	localparam int SLOW_RCP_W = SLOW_SUM_W + 2;
	localparam logic [SLOW_RCP_W-1:0] SLOW_RECIP =
		SLOW_RCP_W'(((64'd1 << SLOW_SHIFT) + 64'(SLOW_WINDOW) - 64'd1) / 64'(SLOW_WINDOW));
	localparam int SLOW_PROD_W = SLOW_SUM_W + SLOW_RCP_W;

	localparam int FAST_SHIFT = SUPPLY_SUM_W + $clog2(FAST_WINDOW);
	localparam int FAST_RCP_W = SUPPLY_SUM_W + 2;
	localparam logic [FAST_RCP_W-1:0] FAST_RECIP =
		FAST_RCP_W'(((64'd1 << FAST_SHIFT) + 64'(FAST_WINDOW) - 64'd1) / 64'(FAST_WINDOW));
	localparam int FAST_PROD_W = SUPPLY_SUM_W + FAST_RCP_W;

	localparam int BLEND_PROD_W = BLEND_W + BLEND_RCP_W;

	logic [SMP_W-1:0] a_avg_q, b_avg_q, sup_avg_q, rev_lvl_q, fwd_lvl_q;

	logic [SLOW_PROD_W-1:0]  a_prod, b_prod;
	logic [FAST_PROD_W-1:0]  sup_prod;
	logic [BLEND_W-1:0]      rev_mix, fwd_mix;
	logic [BLEND_PROD_W-1:0] rev_prod, fwd_prod;
	logic [SMP_W-1:0]        a_avg_d, b_avg_d, sup_avg_d, rev_lvl_d, fwd_lvl_d;
	logic                    fire;

	assign fire     = !job_empty && !res_full;
	assign job_pop  = fire;
	assign res_push = fire;

	always_comb begin
		a_prod   = SLOW_PROD_W'(job.switch_a_sum) * SLOW_PROD_W'(SLOW_RECIP);
		b_prod   = SLOW_PROD_W'(job.switch_b_sum) * SLOW_PROD_W'(SLOW_RECIP);
		sup_prod = FAST_PROD_W'(job.supply_sum) * FAST_PROD_W'(FAST_RECIP);

		rev_mix  = BLEND_W'(rev_lvl_q) + BLEND_W'(job.reverse_peak) * BLEND_W'(9);
		fwd_mix  = BLEND_W'(fwd_lvl_q) + BLEND_W'(job.forward_peak) * BLEND_W'(9);
		rev_prod = BLEND_PROD_W'(rev_mix) * BLEND_PROD_W'(BLEND_RECIP);
		fwd_prod = BLEND_PROD_W'(fwd_mix) * BLEND_PROD_W'(BLEND_RECIP);

		a_avg_d   = job.slow_done ? a_prod[SLOW_SHIFT +: SMP_W] : a_avg_q;
		b_avg_d   = job.slow_done ? b_prod[SLOW_SHIFT +: SMP_W] : b_avg_q;
		sup_avg_d = job.fast_done ? sup_prod[FAST_SHIFT +: SMP_W] : sup_avg_q;
		rev_lvl_d = job.blend_en ? rev_prod[BLEND_SHIFT +: SMP_W] : rev_lvl_q;
		fwd_lvl_d = job.blend_en ? fwd_prod[BLEND_SHIFT +: SMP_W] : fwd_lvl_q;
	end

	always_comb begin
		result.switch_a_mean = a_avg_d;
		result.switch_b_mean = b_avg_d;
		result.supply_mean   = sup_avg_d;
		result.reverse_level = rev_lvl_d;
		result.forward_level = fwd_lvl_d;
		result.slow_done     = job.slow_done;
		result.fast_done     = job.fast_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_avg_q   <= '0;
			b_avg_q   <= '0;
			sup_avg_q <= '0;
			rev_lvl_q <= '0;
			fwd_lvl_q <= '0;
		end else if (fire) begin
			a_avg_q   <= a_avg_d;
			b_avg_q   <= b_avg_d;
			sup_avg_q <= sup_avg_d;
			rev_lvl_q <= rev_lvl_d;
			fwd_lvl_q <= fwd_lvl_d;
		end
	end

endmodule

@@ design/adc_block_average_peak_smoother.sv @@
// Top level of the ADC block average and peak smoother.
// Depends on abaps_pkg, abaps_front, abaps_fifo and abaps_back.
//
// Usage:
//   Input channel is queue-like: drive conv and raise push; the item is taken
//   on a clock edge with push high and full low. Each item is one conversion
//   event (slow switch pair, fast reverse/forward/supply group, or both).
//   Output channel is queue-like too: while empty is low, result holds the
//   oldest waiting item; it is taken on an edge with pop high.
//   Every input item yields exactly one result item, in order.
// Timing:
//   Throughput is one item per cycle while pop keeps up. The front updates
//   the window sums, counters and peaks in the accept cycle and writes a job
//   into a 2-entry queue; the back takes one job per cycle while the result
//   queue has room (one reciprocal multiply per mean, one for each level
//   blend) and writes into a 2-entry result queue.
// Reset:
//   arst_n low clears all sums, counters, peaks, means, levels and both queues.
// Stalls:
//   If pop stays low the result queue fills, the back stops, the job queue
//   fills and full rises; no item is dropped or repeated.
module adc_block_average_peak_smoother #(
	parameter int SLOW_WINDOW = abaps_pkg::SLOW_WINDOW_DEF,
	parameter int FAST_WINDOW = abaps_pkg::FAST_WINDOW_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  abaps_pkg::conv_t    conv,
	output logic                empty,
	input  logic                pop,
	output abaps_pkg::result_t  result
);
	import abaps_pkg::*;

	job_t    front_job;
	job_t    queued_job;
	result_t back_result;
	logic    accept;
	logic    job_empty;
	logic    job_pop;
	logic    res_full;
	logic    res_push;

	assign accept = push && !full;

	abaps_front #(
		.SLOW_WINDOW (SLOW_WINDOW),
		.FAST_WINDOW (FAST_WINDOW)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.conv   (conv),
		.job    (front_job)
	);

	// job queue between front and back
	abaps_fifo #(
		.item_t (job_t),
		.DEPTH  (JOB_DEPTH)
	) u_job_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.wdata  (front_job),
		.full   (full),
		.pop    (job_pop),
		.rdata  (queued_job),
		.empty  (job_empty)
	);

	abaps_back #(
		.SLOW_WINDOW (SLOW_WINDOW),
		.FAST_WINDOW (FAST_WINDOW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (queued_job),
		.job_empty (job_empty),
		.job_pop   (job_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.result    (back_result)
	);

	// result queue toward the consumer
	abaps_fifo #(
		.item_t (result_t),
		.DEPTH  (RES_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (back_result),
		.full   (res_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);

endmodule
